### src/mpv_pkg.sv
// Package: shared types, constants and SHA-512 helpers for the Merkle proof verifier.
`default_nettype none
package mpv_pkg;

  typedef enum logic [1:0] {
    REQ_LEAF     = 2'd0,
    REQ_ARTIFACT = 2'd1,
    REQ_ROOT     = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    VERDICT_MATCH    = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_BAD_POS  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK1,
    ST_BLK2,
    ST_RESULT
  } state_t;

  localparam int NUM_ROUNDS = 80;
  localparam logic [7:0] SIDE_LEFT  = 8'd0;
  localparam logic [7:0] SIDE_RIGHT = 8'd1;
  localparam logic [63:0] ONES_WORD = 64'h0101010101010101;
  localparam logic [63:0] PAD_FIRST = 64'h8000000000000000;
  localparam logic [63:0] PAD_LEN   = 64'd1024;

  typedef logic [7:0][63:0] hash_t;
  typedef logic [15:0][63:0] block_t;

  // Core control: start a compression, report completion.
  typedef struct packed {
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic done;
  } core_sts_t;

  localparam hash_t INIT_H = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

### src/mpv_core.sv
// SHA-512 compression unit: one round per cycle over a 16-word rolling schedule.
`default_nettype none
module mpv_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mpv_pkg::core_ctl_t ctl,
  input  wire mpv_pkg::hash_t   h_in,
  input  wire mpv_pkg::block_t  blk_in,
  output mpv_pkg::core_sts_t    sts,
  output mpv_pkg::hash_t        h_out
);
  import mpv_pkg::*;

  block_t      w_r;
  hash_t       v_r;
  hash_t       h_r;
  logic [6:0]  t_r;
  logic        busy_r;
  logic        done_r;

  logic [63:0] w15, w2, s0, s1, w_new, w_cur, t1, t2, ch, maj, sig0, sig1;

  always_comb begin
    w15   = w_r[1];
    w2    = w_r[14];
    s0    = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    s1    = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = (t_r < 7'd16) ? w_r[0] : w_new;
    sig1  = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sig0  = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sig1 + ch + round_k(t_r) + w_cur;
    t2    = sig0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        t_r    <= '0;
      end else if (busy_r) begin
        if (t_r == 7'(NUM_ROUNDS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        t_r <= t_r + 7'd1;
      end
    end
  end

  // Schedule shifts left one word per round; word 0 is current for rounds 0-15.
  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      w_r <= blk_in;
      v_r <= h_in;
      h_r <= h_in;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) h_out[i] = h_r[i] + v_r[i];
    sts.done = done_r;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without run");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> t_r < 7'(NUM_ROUNDS)) else $error("round overrun");
endmodule
`default_nettype wire

### src/merkle_proof_verify_sha512.sv
// Top level: Merkle inclusion proof verifier with an iterative SHA-512 core.
//
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, in_req_type, in_word_0..7, in_side_byte
// out     | output    | out_valid, out_ready, out_verdict
//
// Leaf, unused and bad-position artifact items keep in_ready high, so the next
// item is taken without waiting. An artifact with a valid position runs two 80-round
// compressions with one round per cycle in the core, each with a start pulse before
// it and a done pulse after it, with in_ready low. A root item holds its verdict in
// the output register until the transfer, with in_ready low. Synchronous active-low
// reset clears state, leaf and running hashes, count, ones and bad flags to zero.
`default_nettype none
module merkle_proof_verify_sha512 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [63:0] in_word_0,
  input  wire logic [63:0] in_word_1,
  input  wire logic [63:0] in_word_2,
  input  wire logic [63:0] in_word_3,
  input  wire logic [63:0] in_word_4,
  input  wire logic [63:0] in_word_5,
  input  wire logic [63:0] in_word_6,
  input  wire logic [63:0] in_word_7,
  input  wire logic [7:0]  in_side_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_verdict
);
  import mpv_pkg::*;

  state_t     state_r, state_nxt;
  hash_t      leaf_r, run_r, sib_r, words;
  logic       side_r;
  logic [1:0] cnt_r;
  logic       ones_r, bad_r;
  logic [1:0] verdict_r;
  logic       acc;
  core_ctl_t  ctl;
  core_sts_t  sts;
  hash_t      core_h_in, core_h_out;
  block_t     core_blk;
  logic       all_ones;

  assign words = {in_word_7, in_word_6, in_word_5, in_word_4,
                  in_word_3, in_word_2, in_word_1, in_word_0};
  assign acc = in_valid && in_ready;
  assign all_ones = (words == {8{ONES_WORD}}) && (in_side_byte == SIDE_RIGHT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && req_t'(in_req_type) == REQ_ARTIFACT &&
            (in_side_byte == SIDE_LEFT || in_side_byte == SIDE_RIGHT)) state_nxt = ST_BLK1;
        else if (acc && req_t'(in_req_type) == REQ_ROOT) state_nxt = ST_RESULT;
      end
      ST_BLK1:   if (sts.done) state_nxt = ST_BLK2;
      ST_BLK2:   if (sts.done) state_nxt = ST_IDLE;
      ST_RESULT: if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Start pulses: first block on entry, pad block once the first finishes.
  logic start_r;
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_RESULT);
    out_verdict = verdict_r;
    ctl.start = start_r;
    core_h_in = (state_r == ST_BLK2) ? run_r : INIT_H;
    if (state_r == ST_BLK2) begin
      core_blk = '0;
      core_blk[0]  = PAD_FIRST;
      core_blk[15] = PAD_LEN;
    end else if (side_r) begin
      core_blk = {sib_r, run_r};
    end else begin
      core_blk = {run_r, sib_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
      leaf_r  <= '0;
      run_r   <= '0;
      cnt_r   <= '0;
      ones_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == ST_IDLE && state_nxt == ST_BLK1) ||
                 (state_r == ST_BLK1 && sts.done);
      if (sts.done) run_r <= core_h_out;
      if (acc) begin
        unique case (req_t'(in_req_type))
          REQ_LEAF: begin
            leaf_r <= words;
            run_r  <= words;
            cnt_r  <= '0;
            ones_r <= 1'b0;
            bad_r  <= 1'b0;
          end
          REQ_ARTIFACT: begin
            if (cnt_r == 2'd0) ones_r <= all_ones;
            if (cnt_r != 2'd2) cnt_r <= cnt_r + 2'd1;
            if (in_side_byte != SIDE_LEFT && in_side_byte != SIDE_RIGHT) bad_r <= 1'b1;
          end
          REQ_ROOT, REQ_UNUSED: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && req_t'(in_req_type) == REQ_ARTIFACT) begin
      sib_r  <= words;
      side_r <= (in_side_byte == SIDE_RIGHT);
    end
    if (acc && req_t'(in_req_type) == REQ_ROOT) begin
      if (cnt_r == 2'd1 && ones_r)
        verdict_r <= (leaf_r == words) ? VERDICT_MATCH : VERDICT_MISMATCH;
      else if (bad_r)
        verdict_r <= VERDICT_BAD_POS;
      else
        verdict_r <= (run_r == words) ? VERDICT_MATCH : VERDICT_MISMATCH;
    end
  end

  mpv_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .h_in   (core_h_in),
    .blk_in (core_blk),
    .sts    (sts),
    .h_out  (core_h_out)
  );

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == ST_BLK1 || state_r == ST_BLK2)) else $error("stray done");
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("count overflow");
endmodule
`default_nettype wire

### dv/merkle_proof_verify_sha512_test.sv
// Testbench for merkle_proof_verify_sha512: predicts proof verdicts and checks each result transfer.
`timescale 1ns / 1ps
`default_nettype none

class verdict_board;
  mpv_pkg::verdict_t pending_verdicts[$];
  int fail_count;
  int report_count;
  logic [63:0] leaf_words[8];
  logic [63:0] chain_words[8];
  int step_count;
  bit ones_first;
  bit side_error;

  function void clear_state();
    for (int i = 0; i < 8; i++) begin
      leaf_words[i] = '0;
      chain_words[i] = '0;
    end
    step_count = 0;
    ones_first = 0;
    side_error = 0;
  endfunction

  static function logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  static function logic [63:0] sha_k(int t);
    logic [63:0] k_tab[80];
    k_tab = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k_tab[t];
  endfunction

  static function void compress_block(ref logic [63:0] h[8], input logic [63:0] blk[16]);
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] wt, t1, t2, w15, w2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        w15 = w[(t - 15) & 15];
        w2 = w[(t - 2) & 15];
        wt = w[t & 15] + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7)) + w[(t - 7) & 15]
           + (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6));
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(t) + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
  endfunction

  // SHA-512 of the 128-byte message lo || hi, into chain_words
  function void hash_into_chain(logic [63:0] lo[8], logic [63:0] hi[8]);
    logic [63:0] h[8];
    logic [63:0] blk[16];
    for (int i = 0; i < 8; i++) begin
      h[i] = mpv_pkg::INIT_H[i];
      blk[i] = lo[i];
      blk[i + 8] = hi[i];
    end
    compress_block(h, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    blk[0] = mpv_pkg::PAD_FIRST;
    blk[15] = mpv_pkg::PAD_LEN;
    compress_block(h, blk);
    for (int i = 0; i < 8; i++) chain_words[i] = h[i];
  endfunction

  function void note_input(logic [1:0] req, logic [63:0] words[8], logic [7:0] side);
    bit ones;
    bit same;
    case (req)
      mpv_pkg::REQ_LEAF: begin
        for (int i = 0; i < 8; i++) begin
          leaf_words[i] = words[i];
          chain_words[i] = words[i];
        end
        step_count = 0;
        ones_first = 0;
        side_error = 0;
      end
      mpv_pkg::REQ_ARTIFACT: begin
        if (step_count == 0) begin
          ones = (side == mpv_pkg::SIDE_RIGHT);
          for (int i = 0; i < 8; i++)
            if (words[i] != mpv_pkg::ONES_WORD) ones = 0;
          ones_first = ones;
        end
        if (step_count < 2) step_count++;
        if (side == mpv_pkg::SIDE_LEFT) hash_into_chain(words, chain_words);
        else if (side == mpv_pkg::SIDE_RIGHT) hash_into_chain(chain_words, words);
        else side_error = 1;
      end
      mpv_pkg::REQ_ROOT: begin
        same = 1;
        if (step_count == 1 && ones_first) begin
          for (int i = 0; i < 8; i++) if (leaf_words[i] != words[i]) same = 0;
          pending_verdicts.push_back(same ? mpv_pkg::VERDICT_MATCH : mpv_pkg::VERDICT_MISMATCH);
        end else if (side_error) begin
          pending_verdicts.push_back(mpv_pkg::VERDICT_BAD_POS);
        end else begin
          for (int i = 0; i < 8; i++) if (chain_words[i] != words[i]) same = 0;
          pending_verdicts.push_back(same ? mpv_pkg::VERDICT_MATCH : mpv_pkg::VERDICT_MISMATCH);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_verdict(logic [1:0] got);
    mpv_pkg::verdict_t want;
    if (pending_verdicts.size() == 0) begin
      fail_count++;
      if (report_count < 10) begin
        report_count++;
        $display("unexpected verdict %0d with nothing pending", got);
      end
      return;
    end
    want = pending_verdicts.pop_front();
    if (got !== want) begin
      fail_count++;
      if (report_count < 10) begin
        report_count++;
        $display("verdict: expected %0d, actual %0d", want, got);
      end
    end
  endfunction
endclass

module merkle_proof_verify_sha512_test;
  import mpv_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic [63:0] in_word_0, in_word_1, in_word_2, in_word_3;
  logic [63:0] in_word_4, in_word_5, in_word_6, in_word_7;
  logic [7:0] in_side_byte;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_verdict;

  verdict_board board;
  bit quiet_phase;
  int sent;

  merkle_proof_verify_sha512 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_word_0(in_word_0), .in_word_1(in_word_1), .in_word_2(in_word_2),
    .in_word_3(in_word_3), .in_word_4(in_word_4), .in_word_5(in_word_5),
    .in_word_6(in_word_6), .in_word_7(in_word_7), .in_side_byte(in_side_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_verdict(out_verdict)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drive one item, hold it until the transfer, note it in the board.
  task automatic send_item(logic [1:0] req, logic [63:0] words[8], logic [7:0] side);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_word_0 <= words[0]; in_word_1 <= words[1]; in_word_2 <= words[2];
    in_word_3 <= words[3]; in_word_4 <= words[4]; in_word_5 <= words[5];
    in_word_6 <= words[6]; in_word_7 <= words[7];
    in_side_byte <= side;
    do @(posedge clk); while (!in_ready);
    board.note_input(req, words, side);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_hash(logic [1:0] req, logic [63:0] w, logic [7:0] side);
    logic [63:0] words[8];
    for (int i = 0; i < 8; i++) words[i] = w;
    send_item(req, words, side);
  endtask

  // Send a root that matches the current chain hash, or a corrupted copy.
  task automatic send_root(bit good);
    logic [63:0] words[8];
    int b;
    for (int i = 0; i < 8; i++) words[i] = board.chain_words[i];
    if (!good) begin
      b = $urandom_range(0, 511);
      words[b / 64][b % 64] = ~words[b / 64][b % 64];
    end
    send_item(REQ_ROOT, words, 8'($urandom()));
  endtask

  task automatic random_proof();
    logic [63:0] words[8];
    int depth;
    foreach (words[i]) words[i] = rand64();
    send_item(REQ_LEAF, words, 8'($urandom()));
    depth = $urandom_range(0, 3);
    for (int d = 0; d < depth; d++) begin
      foreach (words[i]) words[i] = rand64();
      case ($urandom_range(0, 9))
        0: send_item(REQ_ARTIFACT, words, 8'($urandom_range(2, 255)));
        1: send_hash(REQ_ARTIFACT, ONES_WORD, SIDE_RIGHT);
        default: send_item(REQ_ARTIFACT, words, 8'($urandom_range(0, 1)));
      endcase
    end
    send_root($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 7) == 0) send_root($urandom_range(0, 1));
  endtask

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) board.check_verdict(out_verdict);

  initial begin
    #60_000_000;
    $display("merkle_proof_verify_sha512: mismatch");
    $finish;
  end

  initial begin
    logic [63:0] words[8];
    board = new();
    board.clear_state();
    quiet_phase = 0;
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_LEAF;
    {in_word_0, in_word_1, in_word_2, in_word_3} = '0;
    {in_word_4, in_word_5, in_word_6, in_word_7} = '0;
    in_side_byte = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // root before any leaf, then extremes and special cases
    send_hash(REQ_ROOT, 64'h0, 8'h00);
    send_hash(REQ_LEAF, '1, 8'hff);
    send_hash(REQ_ROOT, '1, 8'h00);
    send_hash(REQ_ARTIFACT, '0, SIDE_LEFT);
    send_root(1);
    send_hash(REQ_ARTIFACT, '1, SIDE_RIGHT);
    send_root(0);
    send_hash(REQ_ARTIFACT, 64'h0, 8'hff);
    send_root(1);
    send_hash(REQ_UNUSED, '1, 8'hff);
    send_hash(REQ_LEAF, 64'h1234, 8'h00);
    send_hash(REQ_ARTIFACT, ONES_WORD, SIDE_RIGHT);
    send_hash(REQ_ROOT, 64'h1234, 8'h00);
    send_hash(REQ_ROOT, 64'h1235, 8'h00);
    send_hash(REQ_ARTIFACT, '0, 8'h02);
    send_root(1);
    send_hash(REQ_LEAF, 64'h55, 8'h00);
    send_hash(REQ_ARTIFACT, ONES_WORD, 8'h80);
    send_root(1);
    send_hash(REQ_LEAF, '0, 8'h00);
    send_root(1);

    sent = 0;
    while (sent < 1800) begin
      if (sent > 1650) quiet_phase = 1;
      if ($urandom_range(0, 19) == 0) begin
        foreach (words[i]) words[i] = rand64();
        send_item(2'($urandom()), words, 8'($urandom()));
      end else begin
        random_proof();
      end
    end
    in_valid <= 0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.fail_count == 0 && board.pending_verdicts.size() == 0)
      $display("merkle_proof_verify_sha512: match");
    else
      $display("merkle_proof_verify_sha512: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
src/mpv_pkg.sv
src/mpv_core.sv
src/merkle_proof_verify_sha512.sv
dv/merkle_proof_verify_sha512_test.sv
